FILE: hdl/scc_pkg.sv
package scc_pkg;

  // Sizes of the graph stores
  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int MONEY_BITS = 16;

  localparam int NODE_W   = $clog2(MAX_NODES);
  localparam int CNT_W    = NODE_W + 1;
  localparam int EDGE_W   = $clog2(MAX_EDGES);
  localparam int EFILL_W  = EDGE_W + 1;
  localparam int TOTAL_W  = 26;
  localparam int FUNC_W   = 2;
  localparam int FIELD_W  = 11;
  localparam int AMOUNT_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  // Item function codes
  localparam logic [FUNC_W-1:0] FN_ADD_EDGE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SET_MONEY = 2'd1;
  localparam logic [FUNC_W-1:0] FN_MARK_STOP = 2'd2;
  localparam logic [FUNC_W-1:0] FN_RUN       = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 1'b1;

  // Sequencer steps, also the datapath operation codes
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_CLR     = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE    = 5'd1;
  localparam logic [ST_W-1:0] ST_RCLR    = 5'd2;
  localparam logic [ST_W-1:0] ST_R1_RD   = 5'd3;
  localparam logic [ST_W-1:0] ST_R1_CHK  = 5'd4;
  localparam logic [ST_W-1:0] ST_W_EDGE  = 5'd5;
  localparam logic [ST_W-1:0] ST_W_EDGE2 = 5'd6;
  localparam logic [ST_W-1:0] ST_W_VIS   = 5'd7;
  localparam logic [ST_W-1:0] ST_W_POP   = 5'd8;
  localparam logic [ST_W-1:0] ST_V2CLR   = 5'd9;
  localparam logic [ST_W-1:0] ST_R2_RD   = 5'd10;
  localparam logic [ST_W-1:0] ST_R2_T    = 5'd11;
  localparam logic [ST_W-1:0] ST_R2_CHK  = 5'd12;
  localparam logic [ST_W-1:0] ST_S_RD    = 5'd13;
  localparam logic [ST_W-1:0] ST_S_RD2   = 5'd14;
  localparam logic [ST_W-1:0] ST_S_WR    = 5'd15;
  localparam logic [ST_W-1:0] ST_E_RD    = 5'd16;
  localparam logic [ST_W-1:0] ST_E_RD2   = 5'd17;
  localparam logic [ST_W-1:0] ST_E_RD3   = 5'd18;
  localparam logic [ST_W-1:0] ST_E_WR    = 5'd19;
  localparam logic [ST_W-1:0] ST_D_RD    = 5'd20;
  localparam logic [ST_W-1:0] ST_D_CHK   = 5'd21;
  localparam logic [ST_W-1:0] ST_D_BEST  = 5'd22;
  localparam logic [ST_W-1:0] ST_D_FIN   = 5'd23;
  localparam logic [ST_W-1:0] ST_D_FIN2  = 5'd24;
  localparam logic [ST_W-1:0] ST_F_RD    = 5'd25;
  localparam logic [ST_W-1:0] ST_F_RD2   = 5'd26;
  localparam logic [ST_W-1:0] ST_DONE    = 5'd27;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            second;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic vis;
    logic edge_more;
    logic edge_match;
    logic depth_one;
    logic u_last;
    logic i_zero;
    logic e_more;
    logic end_valid;
    logic dp_hit;
    logic g_zero;
    logic start_ok;
    logic out_busy;
    logic run_req;
  } status_t;

endpackage

FILE: hdl/scc_if.sv
interface scc_in_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::FUNC_W-1:0]    func;
  logic [scc_pkg::FIELD_W-1:0]   node_a;
  logic [scc_pkg::FIELD_W-1:0]   node_b;
  logic [scc_pkg::AMOUNT_W-1:0]  amount;
  modport source (output valid, func, node_a, node_b, amount, input ready);
  modport sink (input valid, func, node_a, node_b, amount, output ready);
endinterface

interface scc_out_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::TOTAL_W-1:0]   best_total;
  logic                          found;
  logic                          overflow;
  modport source (output valid, best_total, found, overflow, input ready);
  modport sink (input valid, best_total, found, overflow, output ready);
endinterface

interface scc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::CFG_IDX_W-1:0] index;
  logic [scc_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/scc_ctrl.sv
module scc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  scc_pkg::status_t sts,
  output scc_pkg::cmd_t    cmd,
  output logic             in_ready
);
  import scc_pkg::*;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            second_r, second_nxt;

  // Next step of the run sequence
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    unique case (state_r)
      ST_CLR:     if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (sts.run_req) state_nxt = ST_RCLR;
      ST_RCLR: begin
        second_nxt = 1'b0;
        if (sts.clr_last) state_nxt = ST_R1_RD;
      end
      ST_R1_RD:   state_nxt = ST_R1_CHK;
      ST_R1_CHK: begin
        if (!sts.vis) state_nxt = ST_W_EDGE;
        else if (sts.u_last) state_nxt = ST_V2CLR;
        else state_nxt = ST_R1_RD;
      end
      ST_W_EDGE: begin
        if (sts.edge_more) state_nxt = ST_W_EDGE2;
        else if (!sts.depth_one) state_nxt = ST_W_POP;
        else if (second_r) state_nxt = sts.i_zero ? ST_S_RD : ST_R2_RD;
        else state_nxt = sts.u_last ? ST_V2CLR : ST_R1_RD;
      end
      ST_W_EDGE2: state_nxt = sts.edge_match ? ST_W_VIS : ST_W_EDGE;
      ST_W_VIS:   state_nxt = ST_W_EDGE;
      ST_W_POP:   state_nxt = ST_W_EDGE;
      ST_V2CLR: begin
        if (sts.clr_last) begin
          state_nxt  = ST_R2_RD;
          second_nxt = 1'b1;
        end
      end
      ST_R2_RD:   state_nxt = ST_R2_T;
      ST_R2_T:    state_nxt = ST_R2_CHK;
      ST_R2_CHK: begin
        if (!sts.vis) state_nxt = ST_W_EDGE;
        else state_nxt = sts.i_zero ? ST_S_RD : ST_R2_RD;
      end
      ST_S_RD:    state_nxt = ST_S_RD2;
      ST_S_RD2:   state_nxt = ST_S_WR;
      ST_S_WR:    state_nxt = sts.u_last ? ST_E_RD : ST_S_RD;
      ST_E_RD:    state_nxt = sts.e_more ? ST_E_RD2 : ST_D_RD;
      ST_E_RD2:   state_nxt = sts.end_valid ? ST_E_RD3 : ST_E_WR;
      ST_E_RD3:   state_nxt = ST_E_WR;
      ST_E_WR:    state_nxt = ST_E_RD;
      ST_D_RD:    state_nxt = sts.e_more ? ST_D_CHK : ST_D_FIN;
      ST_D_CHK:   state_nxt = sts.dp_hit ? ST_D_BEST : ST_D_RD;
      ST_D_BEST:  state_nxt = ST_D_RD;
      ST_D_FIN:   state_nxt = ST_D_FIN2;
      ST_D_FIN2:  state_nxt = sts.g_zero ? ST_F_RD : ST_D_RD;
      ST_F_RD:    state_nxt = sts.start_ok ? ST_F_RD2 : ST_DONE;
      ST_F_RD2:   state_nxt = ST_DONE;
      ST_DONE:    if (!sts.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assign cmd.op     = state_r;
  assign cmd.second = second_r;
  assign in_ready   = (state_r == ST_IDLE);

endmodule

FILE: hdl/scc_dp.sv
module scc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scc_pkg::cmd_t                  cmd,
  output scc_pkg::status_t               sts,
  input  logic                           in_fire,
  input  logic [scc_pkg::FUNC_W-1:0]     in_func,
  input  logic [scc_pkg::FIELD_W-1:0]    in_node_a,
  input  logic [scc_pkg::FIELD_W-1:0]    in_node_b,
  input  logic [scc_pkg::AMOUNT_W-1:0]   in_amount,
  input  logic                           cfg_fire,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scc_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [scc_pkg::TOTAL_W-1:0]    out_best_total,
  output logic                           out_found,
  output logic                           out_overflow
);
  import scc_pkg::*;

  localparam int FRAME_W = NODE_W + EFILL_W;
  localparam int EC_W    = 2 * NODE_W + 1;

  // Memories
  logic [2*NODE_W-1:0]   edge_mem   [MAX_EDGES];
  logic [EC_W-1:0]       ecomp_mem  [MAX_EDGES];
  logic [MONEY_BITS-1:0] money_mem  [MAX_NODES];
  logic                  stop_mem   [MAX_NODES];
  logic                  vis_mem    [MAX_NODES];
  logic [FRAME_W-1:0]    stack_mem  [MAX_NODES];
  logic [NODE_W-1:0]     fin_mem    [MAX_NODES];
  logic [NODE_W-1:0]     comp_mem   [MAX_NODES];
  logic [TOTAL_W-1:0]    cmoney_mem [MAX_NODES];
  logic                  cstop_mem  [MAX_NODES];
  logic [TOTAL_W:0]      best_mem   [MAX_NODES];

  // Memory controls
  logic edge_we, edge_re, ecomp_we, ecomp_re, money_we, money_re, stop_we, stop_re;
  logic vis_we, vis_re, stack_we, stack_re, fin_we, fin_re, comp_we, comp_re;
  logic cmoney_we, cmoney_re, cstop_we, cstop_re, best_we, best_re;
  logic [EDGE_W-1:0]     edge_wa, edge_ra, ecomp_wa, ecomp_ra;
  logic [NODE_W-1:0]     money_wa, stop_wa, vis_wa, vis_ra, stack_wa, stack_ra;
  logic [NODE_W-1:0]     fin_wa, fin_ra, comp_wa, comp_ra, cmoney_wa, cmoney_ra;
  logic [NODE_W-1:0]     cstop_wa, cstop_ra, best_wa, best_ra, s_ra;
  logic [2*NODE_W-1:0]   edge_wd, edge_q;
  logic [EC_W-1:0]       ecomp_wd, ecomp_q;
  logic [MONEY_BITS-1:0] money_wd, money_q;
  logic                  stop_wd, stop_q, vis_wd, vis_q, cstop_wd, cstop_q;
  logic [FRAME_W-1:0]    stack_wd, stack_q;
  logic [NODE_W-1:0]     fin_wd, fin_q, comp_wd, comp_q;
  logic [TOTAL_W-1:0]    cmoney_wd, cmoney_q;
  logic [TOTAL_W:0]      best_wd, best_q;

  // Registers
  logic [CNT_W-1:0]   node_count_r, start_node_r;
  logic [NODE_W-1:0]  clr_r, u_r, i_r, g_r, top_node_r, d_r, cs_r;
  logic [CNT_W-1:0]   fin_fill_r, group_r, depth_r;
  logic [EFILL_W-1:0] top_pos_r, e_r, edge_fill_r;
  logic               ev_r, acc_ok_r, overflow_r, out_valid_r, out_found_r;
  logic [TOTAL_W-1:0] acc_r, out_total_r;

  // Derived values
  logic [CNT_W-1:0]   n_eff;
  logic [NODE_W-1:0]  n_last, a_idx, b_idx, e_src, e_tgt, w_key, w_dst, start_idx;
  logic               a_ok, b_ok, edge_match, end_valid, dp_hit, start_ok, out_busy;
  logic               ec_v;
  logic [NODE_W-1:0]  ec_s, ec_t;

  always_comb begin
    if (node_count_r == '0) n_eff = CNT_W'(1);
    else if (32'(node_count_r) > MAX_NODES) n_eff = CNT_W'(MAX_NODES);
    else n_eff = node_count_r;
  end

  assign n_last    = NODE_W'(n_eff - CNT_W'(1));
  assign a_ok      = (in_node_a != '0) && (32'(in_node_a) <= MAX_NODES);
  assign b_ok      = (in_node_b != '0) && (32'(in_node_b) <= MAX_NODES);
  assign a_idx     = NODE_W'(in_node_a - FIELD_W'(1));
  assign b_idx     = NODE_W'(in_node_b - FIELD_W'(1));
  assign e_src     = edge_q[2*NODE_W-1:NODE_W];
  assign e_tgt     = edge_q[NODE_W-1:0];
  assign w_key     = cmd.second ? e_tgt : e_src;
  assign w_dst     = cmd.second ? e_src : e_tgt;
  assign edge_match = (w_key == top_node_r) && (CNT_W'(w_dst) < n_eff);
  assign end_valid = (CNT_W'(e_src) < n_eff) && (CNT_W'(e_tgt) < n_eff);
  assign ec_v      = ecomp_q[EC_W-1];
  assign ec_s      = ecomp_q[2*NODE_W-1:NODE_W];
  assign ec_t      = ecomp_q[NODE_W-1:0];
  assign dp_hit    = ec_v && (ec_s == g_r) && (ec_t != g_r);
  assign start_ok  = (start_node_r != '0) && (start_node_r <= n_eff);
  assign start_idx = NODE_W'(start_node_r - CNT_W'(1));
  assign out_busy  = out_valid_r && !out_ready;
  assign s_ra      = u_r;

  // Status back to the sequencer
  always_comb begin
    sts.clr_last   = &clr_r;
    sts.vis        = vis_q;
    sts.edge_more  = top_pos_r < edge_fill_r;
    sts.edge_match = edge_match;
    sts.depth_one  = depth_r == CNT_W'(1);
    sts.u_last     = u_r == n_last;
    sts.i_zero     = i_r == '0;
    sts.e_more     = e_r < edge_fill_r;
    sts.end_valid  = end_valid;
    sts.dp_hit     = dp_hit;
    sts.g_zero     = g_r == '0;
    sts.start_ok   = start_ok;
    sts.out_busy   = out_busy;
    sts.run_req    = in_fire && (in_func == FN_RUN);
  end

  // Memory port decode per step
  always_comb begin
    edge_we = 1'b0; edge_re = 1'b0; edge_wa = '0; edge_ra = '0; edge_wd = '0;
    ecomp_we = 1'b0; ecomp_re = 1'b0; ecomp_wa = '0; ecomp_ra = '0; ecomp_wd = '0;
    money_we = 1'b0; money_re = 1'b0; money_wa = '0; money_wd = '0;
    stop_we = 1'b0; stop_re = 1'b0; stop_wa = '0; stop_wd = 1'b0;
    vis_we = 1'b0; vis_re = 1'b0; vis_wa = '0; vis_ra = '0; vis_wd = 1'b0;
    stack_we = 1'b0; stack_re = 1'b0; stack_wa = '0; stack_ra = '0; stack_wd = '0;
    fin_we = 1'b0; fin_re = 1'b0; fin_wa = '0; fin_ra = '0; fin_wd = '0;
    comp_we = 1'b0; comp_re = 1'b0; comp_wa = '0; comp_ra = '0; comp_wd = '0;
    cmoney_we = 1'b0; cmoney_re = 1'b0; cmoney_wa = '0; cmoney_ra = '0; cmoney_wd = '0;
    cstop_we = 1'b0; cstop_re = 1'b0; cstop_wa = '0; cstop_ra = '0; cstop_wd = 1'b0;
    best_we = 1'b0; best_re = 1'b0; best_wa = '0; best_ra = '0; best_wd = '0;
    unique case (cmd.op)
      ST_CLR: begin
        money_we = 1'b1; money_wa = clr_r;
        stop_we  = 1'b1; stop_wa  = clr_r;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_ADD_EDGE: begin
              if (a_ok && b_ok && (32'(edge_fill_r) < MAX_EDGES)) begin
                edge_we = 1'b1;
                edge_wa = EDGE_W'(edge_fill_r);
                edge_wd = {a_idx, b_idx};
              end
            end
            FN_SET_MONEY: begin
              money_we = a_ok; money_wa = a_idx; money_wd = MONEY_BITS'(in_amount);
            end
            FN_MARK_STOP: begin
              stop_we = a_ok; stop_wa = a_idx; stop_wd = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RCLR: begin
        vis_we = 1'b1; vis_wa = clr_r;
        cmoney_we = 1'b1; cmoney_wa = clr_r;
        cstop_we = 1'b1; cstop_wa = clr_r;
        best_we = 1'b1; best_wa = clr_r;
      end
      ST_R1_RD: begin
        vis_re = 1'b1; vis_ra = u_r;
      end
      ST_R1_CHK: begin
        vis_we = !vis_q; vis_wa = u_r; vis_wd = 1'b1;
      end
      ST_W_EDGE: begin
        if (top_pos_r < edge_fill_r) begin
          edge_re = 1'b1; edge_ra = EDGE_W'(top_pos_r);
        end else begin
          fin_we = !cmd.second; fin_wa = NODE_W'(fin_fill_r); fin_wd = top_node_r;
          stack_re = depth_r != CNT_W'(1);
          stack_ra = NODE_W'(depth_r - CNT_W'(2));
        end
      end
      ST_W_EDGE2: begin
        vis_re = edge_match; vis_ra = w_dst;
      end
      ST_W_VIS: begin
        vis_we = !vis_q; vis_wa = d_r; vis_wd = 1'b1;
        stack_we = !vis_q; stack_wa = NODE_W'(depth_r - CNT_W'(1));
        stack_wd = {top_node_r, top_pos_r};
        comp_we = !vis_q && cmd.second; comp_wa = d_r; comp_wd = NODE_W'(group_r);
      end
      ST_V2CLR: begin
        vis_we = 1'b1; vis_wa = clr_r;
      end
      ST_R2_RD: begin
        fin_re = 1'b1; fin_ra = i_r;
      end
      ST_R2_T: begin
        vis_re = 1'b1; vis_ra = fin_q;
      end
      ST_R2_CHK: begin
        vis_we = !vis_q; vis_wa = fin_q; vis_wd = 1'b1;
        comp_we = !vis_q; comp_wa = fin_q; comp_wd = NODE_W'(group_r);
      end
      ST_S_RD: begin
        comp_re = 1'b1; comp_ra = s_ra;
        money_re = 1'b1; stop_re = 1'b1;
      end
      ST_S_RD2: begin
        cmoney_re = 1'b1; cmoney_ra = comp_q;
        cstop_re = 1'b1; cstop_ra = comp_q;
      end
      ST_S_WR: begin
        cmoney_we = 1'b1; cmoney_wa = comp_q;
        cmoney_wd = cmoney_q + TOTAL_W'(money_q);
        cstop_we = 1'b1; cstop_wa = comp_q; cstop_wd = cstop_q | stop_q;
      end
      ST_E_RD: begin
        edge_re = e_r < edge_fill_r; edge_ra = EDGE_W'(e_r);
      end
      ST_E_RD2: begin
        comp_re = end_valid; comp_ra = e_src;
      end
      ST_E_RD3: begin
        comp_re = 1'b1; comp_ra = e_tgt;
      end
      ST_E_WR: begin
        ecomp_we = 1'b1; ecomp_wa = EDGE_W'(e_r); ecomp_wd = {ev_r, cs_r, comp_q};
      end
      ST_D_RD: begin
        ecomp_re = e_r < edge_fill_r; ecomp_ra = EDGE_W'(e_r);
      end
      ST_D_CHK: begin
        best_re = dp_hit; best_ra = ec_t;
      end
      ST_D_FIN: begin
        cmoney_re = 1'b1; cmoney_ra = g_r;
        cstop_re = 1'b1; cstop_ra = g_r;
      end
      ST_D_FIN2: begin
        best_wa = g_r;
        if (acc_ok_r) begin
          best_we = 1'b1; best_wd = {1'b1, cmoney_q + acc_r};
        end else if (cstop_q) begin
          best_we = 1'b1; best_wd = {1'b1, cmoney_q};
        end
      end
      ST_F_RD: begin
        comp_re = start_ok; comp_ra = start_idx;
      end
      ST_F_RD2: begin
        best_re = 1'b1; best_ra = comp_q;
      end
      default: ;
    endcase
  end

  // Memory arrays, registered reads held between reads
  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_q <= edge_mem[edge_ra];
  end
  always_ff @(posedge clk) begin
    if (ecomp_we) ecomp_mem[ecomp_wa] <= ecomp_wd;
    if (ecomp_re) ecomp_q <= ecomp_mem[ecomp_ra];
  end
  always_ff @(posedge clk) begin
    if (money_we) money_mem[money_wa] <= money_wd;
    if (money_re) money_q <= money_mem[s_ra];
  end
  always_ff @(posedge clk) begin
    if (stop_we) stop_mem[stop_wa] <= stop_wd;
    if (stop_re) stop_q <= stop_mem[s_ra];
  end
  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_re) vis_q <= vis_mem[vis_ra];
  end
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (stack_re) stack_q <= stack_mem[stack_ra];
  end
  always_ff @(posedge clk) begin
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    if (fin_re) fin_q <= fin_mem[fin_ra];
  end
  always_ff @(posedge clk) begin
    if (comp_we) comp_mem[comp_wa] <= comp_wd;
    if (comp_re) comp_q <= comp_mem[comp_ra];
  end
  always_ff @(posedge clk) begin
    if (cmoney_we) cmoney_mem[cmoney_wa] <= cmoney_wd;
    if (cmoney_re) cmoney_q <= cmoney_mem[cmoney_ra];
  end
  always_ff @(posedge clk) begin
    if (cstop_we) cstop_mem[cstop_wa] <= cstop_wd;
    if (cstop_re) cstop_q <= cstop_mem[cstop_ra];
  end
  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_wa] <= best_wd;
    if (best_re) best_q <= best_mem[best_ra];
  end

  // Configuration registers, edge fill and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(1);
      start_node_r <= CNT_W'(1);
      edge_fill_r  <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      clr_r        <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_data;
          CFG_START_NODE: start_node_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == ST_CLR || cmd.op == ST_RCLR || cmd.op == ST_V2CLR) begin
        clr_r <= clr_r + NODE_W'(1);
      end
      if (cmd.op == ST_IDLE && in_fire) begin
        if (in_func == FN_ADD_EDGE && a_ok && b_ok) begin
          if (32'(edge_fill_r) >= MAX_EDGES) overflow_r <= 1'b1;
          else edge_fill_r <= edge_fill_r + EFILL_W'(1);
        end
        if (in_func == FN_RUN) clr_r <= '0;
      end
      // a new result may replace one taken in the same cycle
      if (cmd.op == ST_DONE && !out_busy) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // Walk, summing and settling registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ST_RCLR: begin
        if (&clr_r) begin
          u_r <= '0;
          fin_fill_r <= '0;
        end
      end
      ST_R1_CHK: begin
        if (!vis_q) begin
          top_node_r <= u_r;
          top_pos_r  <= '0;
          depth_r    <= CNT_W'(1);
        end else begin
          u_r <= u_r + NODE_W'(1);
        end
      end
      ST_W_EDGE: begin
        if (top_pos_r < edge_fill_r) begin
          top_pos_r <= top_pos_r + EFILL_W'(1);
        end else begin
          if (!cmd.second) fin_fill_r <= fin_fill_r + CNT_W'(1);
          if (depth_r == CNT_W'(1)) begin
            if (cmd.second) begin
              group_r <= group_r + CNT_W'(1);
              i_r <= i_r - NODE_W'(1);
              if (i_r == '0) u_r <= '0;
            end else begin
              u_r <= u_r + NODE_W'(1);
            end
          end
        end
      end
      ST_W_EDGE2: d_r <= w_dst;
      ST_W_VIS: begin
        if (!vis_q) begin
          top_node_r <= d_r;
          top_pos_r  <= '0;
          depth_r    <= depth_r + CNT_W'(1);
        end
      end
      ST_W_POP: begin
        top_node_r <= stack_q[FRAME_W-1:EFILL_W];
        top_pos_r  <= stack_q[EFILL_W-1:0];
        depth_r    <= depth_r - CNT_W'(1);
      end
      ST_V2CLR: begin
        if (&clr_r) begin
          i_r <= NODE_W'(fin_fill_r - CNT_W'(1));
          group_r <= '0;
        end
      end
      ST_R2_CHK: begin
        if (!vis_q) begin
          top_node_r <= fin_q;
          top_pos_r  <= '0;
          depth_r    <= CNT_W'(1);
        end else begin
          i_r <= i_r - NODE_W'(1);
          if (i_r == '0) u_r <= '0;
        end
      end
      ST_S_WR: begin
        u_r <= u_r + NODE_W'(1);
        if (u_r == n_last) e_r <= '0;
      end
      ST_E_RD: begin
        if (!(e_r < edge_fill_r)) begin
          g_r <= NODE_W'(group_r - CNT_W'(1));
          e_r <= '0;
          acc_ok_r <= 1'b0;
        end
      end
      ST_E_RD2: ev_r <= end_valid;
      ST_E_RD3: cs_r <= comp_q;
      ST_E_WR:  e_r <= e_r + EFILL_W'(1);
      ST_D_CHK: if (!dp_hit) e_r <= e_r + EFILL_W'(1);
      ST_D_BEST: begin
        if (best_q[TOTAL_W] && (!acc_ok_r || best_q[TOTAL_W-1:0] > acc_r)) begin
          acc_r <= best_q[TOTAL_W-1:0];
          acc_ok_r <= 1'b1;
        end
        e_r <= e_r + EFILL_W'(1);
      end
      ST_D_FIN2: begin
        if (g_r != '0) begin
          g_r <= g_r - NODE_W'(1);
          e_r <= '0;
          acc_ok_r <= 1'b0;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          out_found_r <= start_ok && best_q[TOTAL_W];
          out_total_r <= (start_ok && best_q[TOTAL_W]) ? best_q[TOTAL_W-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  // Overflow is sampled with the result
  logic out_ovf_r;
  always_ff @(posedge clk) begin
    if (cmd.op == ST_DONE && !out_busy) out_ovf_r <= overflow_r;
  end

  assign out_valid      = out_valid_r;
  assign out_best_total = out_total_r;
  assign out_found      = out_found_r;
  assign out_overflow   = out_ovf_r;

`ifndef SYNTHESIS
  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    edge_fill_r >= $past(edge_fill_r))
    else $error("edge fill went backwards");
  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(overflow_r) |-> overflow_r)
    else $error("overflow flag cleared without reset");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == ST_DONE))
    else $error("result raised outside the done step");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (overflow_r && !$past(overflow_r)) |-> (32'(edge_fill_r) == MAX_EDGES))
    else $error("overflow flagged before the edge table was full");
`endif

endmodule

FILE: hdl/scc_condensed_max_path_sum.sv
// Load items (edge, money, stop mark) are taken one per cycle while the block is idle;
// none gives a result. A run item gives one result after the clearing passes and the
// walk: each depth-first frame scans the edge table, settling scans it once per
// component; no item is taken meanwhile.
// After reset a clearing pass empties money and stop marks; no item is
// taken during it, configuration writes are. Reset is synchronous, active low.
module scc_condensed_max_path_sum (
  input logic       clk,
  input logic       rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch,
  scc_cfg_if.sink   cfg_ch
);
  import scc_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;
  logic    in_fire;
  logic    cfg_fire;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ready;
  assign cfg_fire     = cfg_ch.valid;

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  scc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_fire        (in_fire),
    .in_func        (in_ch.func),
    .in_node_a      (in_ch.node_a),
    .in_node_b      (in_ch.node_b),
    .in_amount      (in_ch.amount),
    .cfg_fire       (cfg_fire),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_best_total (out_ch.best_total),
    .out_found      (out_ch.found),
    .out_overflow   (out_ch.overflow)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  import scc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam longint TOTAL_CAP = 64'd67108863;
  // Edges kept small in the random part: every run scans every loaded edge
  localparam int RANDOM_EDGE_CAP = 120;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               found;
    logic               ovf;
  } path_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  scc_in_if  in_bus();
  scc_out_if out_bus();
  scc_cfg_if cfg_bus();

  scc_condensed_max_path_sum dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  path_result_t pending_paths[$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  // Shadow of the graph stores and registers
  int unsigned g_nodes, g_start;
  int          g_fill;
  bit          g_ovf;
  int          e_src[MAX_EDGES];
  int          e_dst[MAX_EDGES];
  longint      money[MAX_NODES];
  bit          stop_m[MAX_NODES];

  // Scratch for the component search
  int     adj_start[2][MAX_NODES+1];
  int     adj_list[2][MAX_EDGES];
  int     fpos[MAX_NODES];
  bit     seen[MAX_NODES];
  int     stk_node[MAX_NODES];
  int     stk_pos[MAX_NODES];
  int     order[MAX_NODES];
  int     order_fill;
  int     comp[MAX_NODES];
  int     vlist[MAX_NODES];
  int     vfill;
  longint cmoney[MAX_NODES];
  bit     cstop[MAX_NODES];
  longint best[MAX_NODES];
  bit     best_ok[MAX_NODES];
  longint cbest[MAX_NODES];
  bit     cok[MAX_NODES];

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // Adjacency in compressed form; rev swaps the direction of every edge
  function automatic void build_links(bit rev, int n);
    int i, e, a, b;
    for (i = 0; i <= MAX_NODES; i++) adj_start[rev][i] = 0;
    for (e = 0; e < g_fill; e++) begin
      a = rev ? e_dst[e] : e_src[e];
      b = rev ? e_src[e] : e_dst[e];
      if (a < n && b < n) adj_start[rev][a+1]++;
    end
    for (i = 0; i < n; i++) adj_start[rev][i+1] += adj_start[rev][i];
    for (i = 0; i < n; i++) fpos[i] = adj_start[rev][i];
    for (e = 0; e < g_fill; e++) begin
      a = rev ? e_dst[e] : e_src[e];
      b = rev ? e_src[e] : e_dst[e];
      if (a < n && b < n) begin
        adj_list[rev][fpos[a]] = b;
        fpos[a]++;
      end
    end
  endfunction

  // Depth-first walk on an explicit stack; second pass labels a component
  function automatic void dfs(int root, bit second, int group);
    int depth, node, d;
    depth = 1;
    seen[root] = 1'b1;
    stk_node[0] = root;
    stk_pos[0] = adj_start[second][root];
    if (second) begin
      comp[root] = group;
      vlist[vfill] = root;
      vfill++;
    end
    while (depth > 0) begin
      node = stk_node[depth-1];
      if (stk_pos[depth-1] < adj_start[second][node+1]) begin
        d = adj_list[second][stk_pos[depth-1]];
        stk_pos[depth-1]++;
        if (!seen[d] && depth < MAX_NODES) begin
          seen[d] = 1'b1;
          if (second) begin
            comp[d] = group;
            vlist[vfill] = d;
            vfill++;
          end
          stk_node[depth] = d;
          stk_pos[depth] = adj_start[second][d];
          depth++;
        end
      end else begin
        if (!second) begin
          order[order_fill] = node;
          order_fill++;
        end
        depth--;
      end
    end
  endfunction

  // Best money path from the start component to any stop component
  function automatic path_result_t best_path();
    int n, u, i, t, p, v, g, h, e, groups;
    path_result_t r;
    n = g_nodes;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    build_links(1'b0, n);
    build_links(1'b1, n);
    for (i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
    order_fill = 0;
    for (u = 0; u < n; u++) if (!seen[u]) dfs(u, 1'b0, 0);
    for (i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
    vfill = 0;
    groups = 0;
    for (i = order_fill - 1; i >= 0; i--) begin
      t = order[i];
      if (!seen[t]) begin
        dfs(t, 1'b1, groups);
        groups++;
      end
    end
    for (i = 0; i < MAX_NODES; i++) begin
      cmoney[i] = 0; cstop[i] = 1'b0; best[i] = 0;
      best_ok[i] = 1'b0; cbest[i] = 0; cok[i] = 1'b0;
    end
    for (u = 0; u < n; u++) begin
      cmoney[comp[u]] += money[u];
      cstop[comp[u]] |= stop_m[u];
    end
    // components come out in topological order: settle them backwards
    for (p = vfill - 1; p >= 0; p--) begin
      v = vlist[p];
      g = comp[v];
      for (e = adj_start[0][v]; e < adj_start[0][v+1]; e++) begin
        h = comp[adj_list[0][e]];
        if (h != g && best_ok[h]) begin
          if (!cok[g] || best[h] > cbest[g]) cbest[g] = best[h];
          cok[g] = 1'b1;
        end
      end
      if (p == 0 || comp[vlist[p-1]] != g) begin
        if (cok[g]) begin
          best[g] = cmoney[g] + cbest[g];
          best_ok[g] = 1'b1;
        end else if (cstop[g]) begin
          best[g] = cmoney[g];
          best_ok[g] = 1'b1;
        end
      end
    end
    r.total = '0;
    r.found = 1'b0;
    r.ovf = g_ovf;
    if (g_start >= 1 && g_start <= n) begin
      g = comp[g_start-1];
      if (best_ok[g]) begin
        r.total = (best[g] > TOTAL_CAP) ? TOTAL_CAP[TOTAL_W-1:0] : best[g][TOTAL_W-1:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // Shadow update for one accepted item
  function automatic void take_item(logic [FUNC_W-1:0] f, int a, int b,
                                    logic [AMOUNT_W-1:0] amt);
    case (f)
      FN_ADD_EDGE: begin
        if (a >= 1 && a <= MAX_NODES && b >= 1 && b <= MAX_NODES) begin
          if (g_fill >= MAX_EDGES) g_ovf = 1'b1;
          else begin
            e_src[g_fill] = a - 1;
            e_dst[g_fill] = b - 1;
            g_fill++;
          end
        end
      end
      FN_SET_MONEY: if (a >= 1 && a <= MAX_NODES) money[a-1] = amt;
      FN_MARK_STOP: if (a >= 1 && a <= MAX_NODES) stop_m[a-1] = 1'b1;
      default: pending_paths.insert(pending_paths.size(), best_path());
    endcase
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] a,
                           logic [FIELD_W-1:0] b, logic [AMOUNT_W-1:0] amt);
    int gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.func = f;
    in_bus.node_a = a;
    in_bus.node_b = b;
    in_bus.amount = amt;
    do @(posedge clk); while (!in_bus.ready);
    take_item(f, int'(a), int'(b), amt);
  endtask

  task automatic run_search();
    send_item(FN_RUN, FIELD_W'($urandom), FIELD_W'($urandom), AMOUNT_W'($urandom));
  endtask

  // Idle the input, drain every result, then let the block finish loads
  task automatic settle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_paths.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = CFG_DAT_W'(val);
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_NODE_COUNT) g_nodes = val & 11'h7FF;
    else g_start = val & 11'h7FF;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Result sink with random back-pressure
  initial begin
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0 && !calm) begin
        out_bus.ready = 1'b0;
        hold--;
      end else begin
        out_bus.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    path_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_paths.size() == 0) begin
        $error("unexpected result: best_total %0d found %0b overflow %0b",
               out_bus.best_total, out_bus.found, out_bus.overflow);
        errors++;
      end else begin
        exp_r = pending_paths.pop_front();
        if (out_bus.best_total !== exp_r.total) begin
          $error("best_total: expected %0d, got %0d", exp_r.total, out_bus.best_total);
          errors++;
        end
        if (out_bus.found !== exp_r.found) begin
          $error("found: expected %0b, got %0b", exp_r.found, out_bus.found);
          errors++;
        end
        if (out_bus.overflow !== exp_r.ovf) begin
          $error("overflow: expected %0b, got %0b", exp_r.ovf, out_bus.overflow);
          errors++;
        end
      end
    end
  end

  // Widest node range, register extremes and ignored nodes
  task automatic test_extremes();
    write_reg(CFG_NODE_COUNT, 1024);
    write_reg(CFG_START_NODE, 1024);
    send_item(FN_ADD_EDGE, 11'd1024, 11'd1, 16'h0);
    send_item(FN_ADD_EDGE, 11'd1, 11'd1024, 16'hFFFF);
    send_item(FN_ADD_EDGE, 11'd1, 11'd1, 16'h0);
    send_item(FN_SET_MONEY, 11'd1024, 11'h7FF, 16'hFFFF);
    send_item(FN_SET_MONEY, 11'd1, 11'd0, 16'h8001);
    run_search();                         // no stop node yet
    send_item(FN_MARK_STOP, 11'd1, 11'h7FF, 16'hFFFF);
    run_search();
    // out-of-range nodes are ignored
    send_item(FN_ADD_EDGE, 11'd0, 11'd1, 16'h0);
    send_item(FN_ADD_EDGE, 11'd1, 11'h7FF, 16'h0);
    send_item(FN_ADD_EDGE, 11'd1025, 11'd0, 16'h0);
    send_item(FN_SET_MONEY, 11'd0, 11'd5, 16'h1234);
    send_item(FN_SET_MONEY, 11'h7FF, 11'd5, 16'h4321);
    send_item(FN_MARK_STOP, 11'd1025, 11'd0, 16'h0);
    send_item(FN_MARK_STOP, 11'd0, 11'd0, 16'h0);
    settle();
    write_reg(CFG_START_NODE, 0);         // start node zero
    run_search();
    settle();
    write_reg(CFG_NODE_COUNT, 0);         // count zero acts as one
    write_reg(CFG_START_NODE, 1);
    run_search();
    settle();
    write_reg(CFG_NODE_COUNT, 2047);      // above the store: clipped
    run_search();
    settle();
    write_reg(CFG_NODE_COUNT, 2);
    write_reg(CFG_START_NODE, 5);         // start above the nodes in use
    run_search();
    settle();
  endtask

  // Small random graphs, many runs
  task automatic test_random_graphs();
    int batch, k, n, r, a;
    for (batch = 0; batch < 55; batch++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 12);
      write_reg(CFG_NODE_COUNT, ($urandom_range(0, 19) == 0) ? 0 : n);
      if (n < 1) n = 1;
      if ($urandom_range(0, 9) == 0) write_reg(CFG_START_NODE, $urandom_range(0, 2047));
      else write_reg(CFG_START_NODE, $urandom_range(1, n));
      repeat ($urandom_range(14, 34)) begin
        r = $urandom_range(0, 99);
        a = $urandom_range(1, n);
        if (r < 35 && g_fill < RANDOM_EDGE_CAP) begin
          if ($urandom_range(0, 9) == 0)
            send_item(FN_ADD_EDGE, FIELD_W'($urandom_range(1, 1024)),
                      FIELD_W'($urandom_range(1, 1024)), AMOUNT_W'($urandom));
          else
            send_item(FN_ADD_EDGE, FIELD_W'(a), FIELD_W'($urandom_range(1, n)),
                      AMOUNT_W'($urandom));
        end else if (r < 70) begin
          send_item(FN_SET_MONEY,
                    FIELD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : a),
                    FIELD_W'($urandom), AMOUNT_W'($urandom));
        end else if (r < 76) begin
          send_item(FN_MARK_STOP, FIELD_W'(a), FIELD_W'($urandom), AMOUNT_W'($urandom));
        end else if (r < 92) begin
          // ignored: node outside the store
          k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1025, 2047);
          send_item(FUNC_W'($urandom_range(0, 2)), FIELD_W'(k), FIELD_W'($urandom),
                    AMOUNT_W'($urandom));
        end else if (r < 96) begin
          run_search();
        end else begin
          send_item(FN_ADD_EDGE, FIELD_W'(a),
                    FIELD_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1025, 2047)),
                    AMOUNT_W'($urandom));
        end
      end
      run_search();
    end
    calm = 1'b0;
  endtask

  // Many parallel and looping edges on a few nodes
  task automatic test_dense_edges();
    int k;
    settle();
    write_reg(CFG_NODE_COUNT, 3);
    write_reg(CFG_START_NODE, 1);
    for (k = 0; k < 150; k++)
      send_item(FN_ADD_EDGE, FIELD_W'($urandom_range(1, 3)), FIELD_W'($urandom_range(1, 3)),
                AMOUNT_W'($urandom));
    run_search();
    send_item(FN_SET_MONEY, 11'd2, 11'd0, 16'hFFFF);
    send_item(FN_MARK_STOP, 11'd3, 11'd0, 16'h0);
    run_search();
    settle();
  endtask

  initial begin
    int i;
    in_bus.valid = 1'b0;
    in_bus.func = FN_ADD_EDGE;
    in_bus.node_a = '0;
    in_bus.node_b = '0;
    in_bus.amount = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_NODE_COUNT;
    cfg_bus.data = '0;
    g_nodes = 1;
    g_start = 1;
    g_fill = 0;
    g_ovf = 1'b0;
    for (i = 0; i < MAX_NODES; i++) begin
      money[i] = 0;
      stop_m[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_random_graphs();
    test_dense_edges();

    while (pending_paths.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_paths.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
